// ----- rtl/core/polar_pose_regulator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Polar pose regulator assertion macros
// Shared concurrent assertion forms for the regulator modules.
// ----------------------------------------------------------------------------
`ifndef POLAR_POSE_REGULATOR_TOP_MACROS_SVH
`define POLAR_POSE_REGULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define PPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// Polar pose regulator package
// Command and status types, CORDIC constants and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_GAIN_DISTANCE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_ALPHA    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_BETA     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GOAL_RADIUS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GOAL_X        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GOAL_Y        = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GOAL_HEADING  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_GOAL_ARMED    = 3'd7;

  // Angles in Q30 radians
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       iter;
    logic [4:0] iter_idx;
    logic       mag;
    logic       post;
    logic       mul;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic active;
  } stat_t;

  // atan(2^-i) in Q30
  function automatic logic signed [34:0] atan_entry(input logic [4:0] i);
    logic signed [34:0] r;
    case (i)
      5'd0:    r = 35'sd843314857;
      5'd1:    r = 35'sd497837829;
      5'd2:    r = 35'sd263043837;
      5'd3:    r = 35'sd133525159;
      5'd4:    r = 35'sd67021687;
      5'd5:    r = 35'sd33543516;
      5'd6:    r = 35'sd16775851;
      5'd7:    r = 35'sd8388437;
      5'd8:    r = 35'sd4194283;
      5'd9:    r = 35'sd2097149;
      5'd10:   r = 35'sd1048576;
      5'd31:   r = 35'sd0;
      default: r = 35'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // Clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
    logic signed [31:0] r;
    if (v > 62'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -62'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ppr_in_if.sv -----
// ----------------------------------------------------------------------------
// Polar pose regulator channels
// Valid/ready channels for pose transactions and command transactions.
// ----------------------------------------------------------------------------
interface ppr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic               pose_valid;
  modport source (output valid, pos_x, pos_y, heading, pose_valid, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, pose_valid, output ready);
endinterface

interface ppr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] turn_command;
  logic signed [31:0] speed_command;
  logic               at_goal;
  logic               regulating;
  modport source (output valid, turn_command, speed_command, at_goal, regulating,
                  input ready);
  modport sink   (input valid, turn_command, speed_command, at_goal, regulating,
                  output ready);
endinterface

// ----- rtl/core/polar_pose_regulator_top.sv -----
// ----------------------------------------------------------------------------
// Polar pose regulator top level
// Unicycle pose regulator in polar form, Q16.16, with CORDIC vectoring.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_ch    | in  | pos_x, pos_y, heading, pose_valid
//  out_ch   | out | turn_command, speed_command, at_goal, regulating
//  cfg_*    | in  | write enable, register index, write data
//
// A pose transaction passes through load, the CORDIC iteration loop,
// magnitude, post, multiply and commit states; an invalid pose or unarmed
// goal goes from load straight to commit. Reset is synchronous and clears
// control and held state. The next pose is taken while a result waits; the
// result slot stalls commit until the previous result is taken.
module polar_pose_regulator_top #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppr_in_if.sink                       in_ch,
  ppr_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ppr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ppr_pkg::CfgDataW-1:0] cfg_data
);

  ppr_pkg::cmd_t  cmd;
  ppr_pkg::stat_t stat;

  ppr_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pos_x         (in_ch.pos_x),
    .pos_y         (in_ch.pos_y),
    .heading       (in_ch.heading),
    .pose_valid    (in_ch.pose_valid),
    .cmd           (cmd),
    .stat          (stat),
    .turn_command  (out_ch.turn_command),
    .speed_command (out_ch.speed_command),
    .at_goal       (out_ch.at_goal),
    .regulating    (out_ch.regulating)
  );

endmodule

// ----- rtl/core/ppr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Polar pose regulator controller
// Sequences capture, CORDIC iterations, multiplies and result commit.
// ----------------------------------------------------------------------------
`include "polar_pose_regulator_top_macros.svh"

module ppr_ctrl #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ppr_pkg::stat_t stat,
  output ppr_pkg::cmd_t  cmd
);

  localparam int unsigned CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_ITER = 7'b0000100,
    S_MAG  = 7'b0001000,
    S_POST = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_FIN  = 7'b1000000
  } ppr_state_t;

  ppr_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_fire, commit, last_iter;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign commit    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign last_iter = (cnt_r == CntW'(CORDIC_STEPS - 1));

  // Drive datapath commands
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_fire;
    cmd.load     = (state_r == S_LOAD);
    cmd.iter     = (state_r == S_ITER);
    cmd.iter_idx = 5'(cnt_r);
    cmd.mag      = (state_r == S_MAG);
    cmd.post     = (state_r == S_POST);
    cmd.mul      = (state_r == S_MUL);
    cmd.commit   = commit;
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = stat.active ? S_ITER : S_FIN;
      end
      S_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_iter) state_nxt = S_MAG;
      end
      S_MAG:  state_nxt = S_POST;
      S_POST: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_FIN: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result slot until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PPR_ASSERT_NEXT(a_fire_load, in_fire, state_r == S_LOAD, "accept did not start load")
  `PPR_ASSERT_NEXT(a_iter_done, (state_r == S_ITER) && last_iter, state_r == S_MAG,
                   "iteration count overran")
  `PPR_ASSERT_NEXT(a_commit_out, commit, out_valid_r, "committed result not presented")

endmodule

// ----- rtl/core/ppr_dp.sv -----
// ----------------------------------------------------------------------------
// Polar pose regulator datapath
// Configuration registers, CORDIC vectoring, gain multiplies and held state.
// ----------------------------------------------------------------------------
module ppr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ppr_pkg::CfgDataW-1:0]    cfg_data,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [18:0]              heading,
  input  logic                            pose_valid,
  input  ppr_pkg::cmd_t                   cmd,
  output ppr_pkg::stat_t                  stat,
  output logic signed [31:0]              turn_command,
  output logic signed [31:0]              speed_command,
  output logic                            at_goal,
  output logic                            regulating
);

  // Configuration
  logic [23:0] kp_r, ka_r;
  logic signed [23:0] kb_r;
  logic [30:0] radius_r;
  logic signed [31:0] gx_r, gy_r;
  logic signed [18:0] gh_r;
  logic armed_r;

  // Captured transaction
  logic signed [31:0] px_r, py_r;
  logic signed [18:0] hd_r;
  logic active_r, zero_r;

  // CORDIC
  logic signed [51:0] x_r, y_r;
  logic signed [34:0] z_r;

  // Magnitude and angle stages
  logic [56:0] phi_r;
  logic [29:0] plo_r;
  logic [35:0] rho_r;
  logic near_r, dir_neg_r;
  logic signed [21:0] a16_r;
  logic signed [23:0] beta_r;
  logic signed [46:0] om_a_r;
  logic signed [47:0] om_b_r;
  logic [59:0] v_r;

  // Held state
  logic latch_valid_r, latch_neg_r;
  logic signed [31:0] held_turn_r, held_speed_r;
  logic at_goal_r, regulating_r;

  // Combinational helpers
  logic signed [32:0] dx, dy;
  logic signed [51:0] x0, y0, xs, ys;
  logic signed [34:0] at;
  logic [57:0] rsum;
  logic signed [35:0] ang, a30, a30r;
  logic signed [61:0] om, om_s, v_s;
  logic neg_eff;

  assign stat.active   = active_r;
  assign turn_command  = held_turn_r;
  assign speed_command = held_speed_r;
  assign at_goal       = at_goal_r;
  assign regulating    = regulating_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= 24'd65536;
      ka_r     <= 24'd65536;
      kb_r     <= '0;
      radius_r <= '0;
      gx_r     <= '0;
      gy_r     <= '0;
      gh_r     <= '0;
      armed_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppr_pkg::REG_GAIN_DISTANCE: kp_r     <= cfg_data[23:0];
        ppr_pkg::REG_GAIN_ALPHA:    ka_r     <= cfg_data[23:0];
        ppr_pkg::REG_GAIN_BETA:     kb_r     <= cfg_data[23:0];
        ppr_pkg::REG_GOAL_RADIUS:   radius_r <= cfg_data[30:0];
        ppr_pkg::REG_GOAL_X:        gx_r     <= cfg_data[31:0];
        ppr_pkg::REG_GOAL_Y:        gy_r     <= cfg_data[31:0];
        ppr_pkg::REG_GOAL_HEADING:  gh_r     <= cfg_data[18:0];
        ppr_pkg::REG_GOAL_ARMED:    armed_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the pose transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r     <= pos_x;
      py_r     <= pos_y;
      hd_r     <= heading;
      active_r <= pose_valid && armed_r;
    end
  end

  // Error vector, prescaled; the load folds it into the right half plane
  always_comb begin
    dx = 33'(gx_r) - 33'(px_r);
    dy = 33'(gy_r) - 33'(py_r);
    x0 = 52'(dx) <<< 16;
    y0 = 52'(dy) <<< 16;
  end

  // CORDIC vectoring step
  always_comb begin
    xs = x_r >>> cmd.iter_idx;
    ys = y_r >>> cmd.iter_idx;
    at = ppr_pkg::atan_entry(cmd.iter_idx);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zero_r <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= (dy >= 0) ? ppr_pkg::PI_Q30 : -ppr_pkg::PI_Q30;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (cmd.iter) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
  end

  // Gain correction split into high and low partial products
  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      phi_r <= 57'(x_r[50:24]) * 57'(ppr_pkg::INV_GAIN_Q30);
      plo_r <= 30'((54'(x_r[23:0]) * 54'(ppr_pkg::INV_GAIN_Q30)) >> 24);
    end
  end

  // Distance, bearing error and heading error
  always_comb begin
    rsum = 58'(phi_r) + 58'(plo_r) + 58'd2097152;
    ang  = zero_r ? 36'sd0 : 36'(z_r);
    a30  = ang - (36'(hd_r) <<< 14);
    a30r = a30 + 36'sd8192;
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      rho_r     <= 36'(rsum >> 22);
      near_r    <= (36'(rsum >> 22) < 36'(radius_r));
      dir_neg_r <= !((a30 > -36'(ppr_pkg::HALF_PI_Q30)) &&
                     (a30 <= 36'(ppr_pkg::HALF_PI_Q30)));
      a16_r     <= 22'(a30r >>> 14);
      beta_r    <= 24'(gh_r) - 24'(hd_r) - 24'(a30r >>> 14);
    end
  end

  // Gain products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      om_a_r <= $signed({1'b0, ka_r}) * 47'(a16_r);
      om_b_r <= 48'(kb_r) * 48'(beta_r);
      v_r    <= 60'(kp_r) * 60'(rho_r);
    end
  end

  // Round and saturate the commands
  always_comb begin
    neg_eff = latch_valid_r ? latch_neg_r : dir_neg_r;
    om      = 62'(om_a_r) + 62'(om_b_r);
    om_s    = (dir_neg_r ? -om : om) + 62'sd32768;
    v_s     = (neg_eff ? -$signed(62'(v_r)) : $signed(62'(v_r))) + 62'sd32768;
  end

  // Commit the result and update held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_valid_r <= 1'b0;
      latch_neg_r   <= 1'b0;
      held_turn_r   <= '0;
      held_speed_r  <= '0;
      at_goal_r     <= 1'b0;
      regulating_r  <= 1'b0;
    end else if (cmd.commit) begin
      if (!active_r) begin
        latch_valid_r <= 1'b0;
        at_goal_r     <= 1'b0;
        regulating_r  <= 1'b0;
      end else if (near_r) begin
        latch_valid_r <= 1'b0;
        held_turn_r   <= '0;
        held_speed_r  <= '0;
        at_goal_r     <= 1'b1;
        regulating_r  <= 1'b0;
      end else begin
        latch_valid_r <= 1'b1;
        latch_neg_r   <= neg_eff;
        held_turn_r   <= ppr_pkg::sat32(om_s >>> 16);
        held_speed_r  <= ppr_pkg::sat32(v_s >>> 16);
        at_goal_r     <= 1'b0;
        regulating_r  <= 1'b1;
      end
    end
  end

endmodule
